>>> rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, widths, constants and the arctangent table for the
// go-to-goal proportional controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

   // field widths
   localparam int POS_W      = 16;
   localparam int LIN_W      = 24;
   localparam int ANGV_W     = 24;
   localparam int CSR_IDX_W  = 3;

   // internal widths
   localparam int DX_W       = POS_W + 1;        // goal minus pose, Q9.8
   localparam int CX_W       = 28;               // cordic x/y, Q9.16 with growth
   localparam int Z_W        = 36;               // cordic angle, Q.32 radians
   localparam int MA_W       = 33;               // multiplier operand a
   localparam int MB_W       = CX_W;             // multiplier operand b
   localparam int PROD_W     = MA_W + MB_W;
   localparam int DIST_W     = 17;               // distance, unsigned Q9.8
   localparam int ANG_W      = Z_W - 20;         // angle to goal, Q4.12
   localparam int DIFF_W     = ANG_W + 1;        // heading error, Q5.12
   localparam int ATAN_IDX_W = 5;

   // cordic iteration count
   localparam int CORDIC_ITERATIONS_DEFAULT = 16;

   // fixed-point constants
   localparam logic signed [Z_W-1:0] Q32_PI       = 36'sd13493037705;
   localparam logic        [31:0]    Q32_INV_GAIN = 32'd2608131496;
   localparam int                    LIN_MAX      = 16777215;
   localparam int                    ANG_MAX      = 8388607;
   localparam int                    ANG_MIN      = -8388608;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_X          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_Y          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REACH_TOLERANCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGULAR_GAIN    = 3'd4;

   // register reset values
   localparam logic [POS_W-1:0] TOLERANCE_RESET    = 16'd384;
   localparam logic [POS_W-1:0] LINEAR_GAIN_RESET  = 16'd384;
   localparam logic [POS_W-1:0] ANGULAR_GAIN_RESET = 16'd1536;

   // payload words
   typedef struct packed {
      logic signed [POS_W-1:0] pose_x;
      logic signed [POS_W-1:0] pose_y;
      logic signed [POS_W-1:0] heading;
   } req_type;

   typedef struct packed {
      logic                     command_valid;
      logic                     goal_reached;
      logic        [LIN_W-1:0]  fwd_speed;
      logic signed [ANGV_W-1:0] turn_rate;
   } rsp_type;

   // cordic control and status
   typedef struct packed {
      logic                   load;
      logic signed [CX_W-1:0] x0;
      logic signed [CX_W-1:0] y0;
      logic signed [Z_W-1:0]  z0;
   } cordic_ctrl_type;

   typedef struct packed {
      logic                   busy;
      logic signed [CX_W-1:0] x;
      logic signed [Z_W-1:0]  z;
   } cordic_status_type;

   // atan(2^-i) in Q.32, series truncated term by term
   function automatic logic signed [Z_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 36'sd3373259426;
         5'd1:    val = 36'sd1991351316;
         5'd2:    val = 36'sd1052175345;
         5'd3:    val = 36'sd534100635;
         5'd4:    val = 36'sd268086748;
         5'd5:    val = 36'sd134174063;
         5'd6:    val = 36'sd67103403;
         5'd7:    val = 36'sd33553750;
         5'd8:    val = 36'sd16777131;
         5'd9:    val = 36'sd8388598;
         5'd10:   val = 36'sd4194303;
         5'd11:   val = 36'sd2097152;
         5'd12:   val = 36'sd1048576;
         5'd13:   val = 36'sd524288;
         5'd14:   val = 36'sd262144;
         5'd15:   val = 36'sd131072;
         5'd16:   val = 36'sd65536;
         5'd17:   val = 36'sd32768;
         5'd18:   val = 36'sd16384;
         5'd19:   val = 36'sd8192;
         5'd20:   val = 36'sd4096;
         5'd21:   val = 36'sd2048;
         5'd22:   val = 36'sd1024;
         5'd23:   val = 36'sd512;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative vectoring cordic: one micro-rotation per cycle through a shared
// barrel shifter and add/subtract, giving vector length (times gain) and angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic #(
   parameter int ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  gtg_pkg::cordic_ctrl_type   ctrl,
   output gtg_pkg::cordic_status_type status
);
   import gtg_pkg::*;

   localparam int                ITER_W    = $clog2(ITERATIONS);
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITERATIONS - 1);

   logic signed [CX_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic                   busy_ff, busy_in;

   logic signed [CX_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  atan_val;

   // shifted operands and table angle for this iteration
   always_comb begin
      xs       = x_ff >>> iter_ff;
      ys       = y_ff >>> iter_ff;
      atan_val = atan_lookup(ATAN_IDX_W'(iter_ff));
   end

   // micro-rotation towards the x axis
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      if (ctrl.load) begin
         x_in    = ctrl.x0;
         y_in    = ctrl.y0;
         z_in    = ctrl.z0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[CX_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
            iter_in = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign status.busy = busy_ff;
   assign status.x    = x_ff;
   assign status.z    = z_ff;

endmodule

`default_nettype wire

>>> rtl/gtg_mul.sv
// ----------------------------------------------------------------------------
// gtg_mul
// Shared signed multiplier with a registered product, used for gain
// removal and both velocity gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_mul (
   input  wire                                  clock,
   input  wire logic signed [gtg_pkg::MA_W-1:0]   mul_a,
   input  wire logic signed [gtg_pkg::MB_W-1:0]   mul_b,
   output logic signed [gtg_pkg::PROD_W-1:0]      prod
);
   import gtg_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // full-width product
   always_comb begin
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/go_to_goal_p_controller_core.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_core
// Proportional go-to-goal controller: pose in, velocity command out.
// ----------------------------------------------------------------------------
// Each pose word gives exactly one response word. The block takes one pose at
// a time and takes no new pose until its response word is in the response
// register. The work on each pose is done by the vectoring cordic, which does
// one micro-rotation a cycle, followed by three passes through a single shared
// multiplier. Once the goal has been reached, a pose goes from the idle state
// straight to the finish state and is answered with no command. The response
// register lets a new pose be taken while the last response waits. Register
// writes are taken at any time but must only be made while the block is idle;
// the reached flag is cleared by reset alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller_core #(
   parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // pose channel
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  gtg_pkg::req_type                       req_data,
   // response channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output gtg_pkg::rsp_type                       rsp_data,
   // register write channel
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gtg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gtg_pkg::POS_W-1:0]         csr_data
);
   import gtg_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_PREP   = 9'b000000010,
      S_ROTATE = 9'b000000100,
      S_DIST   = 9'b000001000,
      S_CMP    = 9'b000010000,
      S_LIN    = 9'b000100000,
      S_ANG    = 9'b001000000,
      S_SAT    = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   localparam int SH_W     = PROD_W - 8;
   localparam int DIST_SH  = 40;
   localparam int ANGLE_SH = 20;
   localparam logic signed [SH_W-1:0] ANGV_HI = SH_W'(ANG_MAX);
   localparam logic signed [SH_W-1:0] ANGV_LO = SH_W'(ANG_MIN);

   state_type state_ff, state_in;
   logic      reached_ff, reached_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic        [POS_W-1:0] tol_ff, lin_gain_ff, ang_gain_ff;

   req_type                   pose_ff, pose_in;
   logic        [DIST_W-1:0]  dist_ff, dist_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      res_cmd_ff, res_cmd_in;
   logic                      res_reached_ff, res_reached_in;
   logic        [LIN_W-1:0]   res_lin_ff, res_lin_in;
   logic signed [ANGV_W-1:0]  res_angv_ff, res_angv_in;

   cordic_ctrl_type   cordic_ctrl;
   cordic_status_type cordic_status;

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [DX_W-1:0]   dx, dy;
   logic signed [CX_W-1:0]   x_ext, y_ext;
   logic signed [PROD_W-1:0] dist_sum, round_sum;
   logic signed [SH_W-1:0]   round_sh;
   logic signed [Z_W-1:0]    z_sum;
   logic signed [ANG_W-1:0]  ang;
   logic                     out_free;

   // shared arithmetic units
   gtg_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cordic_ctrl),
      .status (cordic_status)
   );

   gtg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // vector to goal, pre-rotated into the right half plane
   always_comb begin
      dx    = {goal_x_ff[POS_W-1], goal_x_ff} - {pose_ff.pose_x[POS_W-1], pose_ff.pose_x};
      dy    = {goal_y_ff[POS_W-1], goal_y_ff} - {pose_ff.pose_y[POS_W-1], pose_ff.pose_y};
      x_ext = {{(CX_W-DX_W-8){dx[DX_W-1]}}, dx, 8'b0};
      y_ext = {{(CX_W-DX_W-8){dy[DX_W-1]}}, dy, 8'b0};
      cordic_ctrl.load = (state_ff == S_PREP);
      if (dx[DX_W-1]) begin
         cordic_ctrl.x0 = -x_ext;
         cordic_ctrl.y0 = -y_ext;
         cordic_ctrl.z0 = dy[DX_W-1] ? -Q32_PI : Q32_PI;
      end else begin
         cordic_ctrl.x0 = x_ext;
         cordic_ctrl.y0 = y_ext;
         cordic_ctrl.z0 = '0;
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DIST: begin
            mul_a = MA_W'(Q32_INV_GAIN);
            mul_b = cordic_status.x;
         end
         S_LIN: begin
            mul_a = MA_W'(lin_gain_ff);
            mul_b = MB_W'(dist_ff);
         end
         S_ANG: begin
            mul_a = MA_W'(ang_gain_ff);
            mul_b = MB_W'(diff_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // rounding of the distance, angle and products
   always_comb begin
      dist_sum  = prod + (PROD_W'(1) <<< (DIST_SH - 1));
      z_sum     = cordic_status.z + (Z_W'(1) <<< (ANGLE_SH - 1));
      ang       = z_sum[Z_W-1:ANGLE_SH];
      round_sum = prod + PROD_W'(128);
      round_sh  = round_sum[PROD_W-1:8];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      reached_in     = reached_ff;
      pose_in        = pose_ff;
      dist_in        = dist_ff;
      diff_in        = diff_ff;
      res_cmd_in     = res_cmd_ff;
      res_reached_in = res_reached_ff;
      res_lin_in     = res_lin_ff;
      res_angv_in    = res_angv_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pose_in = req_data;
               if (reached_ff) begin
                  res_cmd_in     = 1'b0;
                  res_reached_in = 1'b1;
                  res_lin_in     = '0;
                  res_angv_in    = '0;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            state_in = S_ROTATE;
         end
         S_ROTATE: begin
            if (!cordic_status.busy) begin
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            dist_in = dist_sum[DIST_SH+DIST_W-1:DIST_SH];
            diff_in = {ang[ANG_W-1], ang} - {pose_ff.heading[POS_W-1], pose_ff.heading};
            if (dist_in <= {1'b0, tol_ff}) begin
               reached_in     = 1'b1;
               res_cmd_in     = 1'b0;
               res_reached_in = 1'b1;
               res_lin_in     = '0;
               res_angv_in    = '0;
               state_in       = S_FINISH;
            end else begin
               state_in = S_LIN;
            end
         end
         S_LIN: begin
            state_in = S_ANG;
         end
         S_ANG: begin
            // linear product is never negative
            if (round_sh[SH_W-1:LIN_W] != '0) begin
               res_lin_in = LIN_W'(LIN_MAX);
            end else begin
               res_lin_in = round_sh[LIN_W-1:0];
            end
            state_in = S_SAT;
         end
         S_SAT: begin
            if (round_sh > ANGV_HI) begin
               res_angv_in = ANGV_W'(ANG_MAX);
            end else if (round_sh < ANGV_LO) begin
               res_angv_in = ANGV_W'(ANG_MIN);
            end else begin
               res_angv_in = round_sh[ANGV_W-1:0];
            end
            res_cmd_in     = 1'b1;
            res_reached_in = 1'b0;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_FINISH && out_free) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.command_valid  = res_cmd_ff;
         rsp_data_in.goal_reached   = res_reached_ff;
         rsp_data_in.fwd_speed      = res_lin_ff;
         rsp_data_in.turn_rate      = res_angv_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reached_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         tol_ff      <= TOLERANCE_RESET;
         lin_gain_ff <= LINEAR_GAIN_RESET;
         ang_gain_ff <= ANGULAR_GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GOAL_X:          goal_x_ff   <= csr_data;
            REG_GOAL_Y:          goal_y_ff   <= csr_data;
            REG_REACH_TOLERANCE: tol_ff      <= csr_data;
            REG_LINEAR_GAIN:     lin_gain_ff <= csr_data;
            REG_ANGULAR_GAIN:    ang_gain_ff <= csr_data;
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pose_ff        <= pose_in;
      dist_ff        <= dist_in;
      diff_ff        <= diff_in;
      res_cmd_ff     <= res_cmd_in;
      res_reached_ff <= res_reached_in;
      res_lin_ff     <= res_lin_in;
      res_angv_ff    <= res_angv_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

>>> rtl/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Port-level checks for the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input gtg_pkg::rsp_type rsp_data
);
   import gtg_pkg::*;

   logic reached_seen_ff, reached_seen_in;

   // remembers that a reached word has been delivered
   always_comb begin
      reached_seen_in = reached_seen_ff;
      if (rsp_valid && rsp_ready && rsp_data.goal_reached) begin
         reached_seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_seen_ff <= 1'b0;
      end else begin
         reached_seen_ff <= reached_seen_in;
      end
   end

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a word carries either a command or the reached flag
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.command_valid != rsp_data.goal_reached))
      else $error("command and reached flag not exclusive");

   // once reached, every later word is an empty reached word
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reached_seen_ff |->
         rsp_data.goal_reached && !rsp_data.command_valid &&
         (rsp_data.fwd_speed == '0) && (rsp_data.turn_rate == '0))
      else $error("command issued after goal reached");

   // one pose at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pose taken while busy");

endmodule

bind go_to_goal_p_controller_core gtg_checker u_gtg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the go-to-goal proportional controller core. Pose
// words go in through a valid/ready channel with random gaps. Every accepted
// pose is run through a bit-exact software copy of the CORDIC steering path,
// and each response word is compared field by field with the oldest
// prediction. Register settings change only between batches, once the block
// has drained. Goal capture is left until the very end, because the reached
// flag can only be cleared by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import gtg_pkg::*;

   // spare register indexes, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [POS_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_order = 0;

   // bit-exact steering predictor and store of expected response words
   class pose_scoreboard;
      localparam longint PI_Q32 = 64'sd13493037705;
      localparam longint QUARTER_PI_Q32 = 64'sd3373259426;
      localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;

      logic signed [POS_W-1:0] goal_x = '0;
      logic signed [POS_W-1:0] goal_y = '0;
      logic [POS_W-1:0] tolerance = TOLERANCE_RESET;
      logic [POS_W-1:0] lin_gain = LINEAR_GAIN_RESET;
      logic [POS_W-1:0] ang_gain = ANGULAR_GAIN_RESET;
      bit reached = 1'b0;
      rsp_type expected_q[$];
      int unsigned errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] value);
         case (idx)
            REG_GOAL_X:          goal_x = value;
            REG_GOAL_Y:          goal_y = value;
            REG_REACH_TOLERANCE: tolerance = value;
            REG_LINEAR_GAIN:     lin_gain = value;
            REG_ANGULAR_GAIN:    ang_gain = value;
            default: ;
         endcase
      endfunction

      // arctangent of 2^-i in Q.32 from its power series
      function longint atan_entry(int unsigned i);
         longint acc;
         longint term;
         bit neg;
         if (i == 0) return QUARTER_PI_Q32;
         acc = 0;
         neg = 1'b0;
         for (int unsigned k = 1; i * k <= 32; k += 2) begin
            term = longint'((64'd1 << (32 - i * k)) / k);
            acc = neg ? acc - term : acc + term;
            neg = !neg;
         end
         return acc;
      endfunction

      // vectoring cordic on goal minus pose: Q9.8 distance and Q4.12 bearing
      function void steer(req_type p, output longint unsigned span, output longint bearing);
         longint x;
         longint y;
         longint z;
         longint xs;
         longint ys;
         x = (longint'(goal_x) - longint'($signed(p.pose_x))) * 256;
         y = (longint'(goal_y) - longint'($signed(p.pose_y))) * 256;
         z = 0;
         // left half plane, pre-rotate by pi
         if (x < 0) begin
            z = (y >= 0) ? PI_Q32 : -PI_Q32;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_ITERATIONS_DEFAULT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
               x -= ys;
               y += xs;
               z -= atan_entry(i);
            end else begin
               x += ys;
               y -= xs;
               z += atan_entry(i);
            end
         end
         span = ($unsigned(x) * INV_GAIN_Q32 + (64'd1 << 39)) >> 40;
         bearing = (z + (longint'(1) << 19)) >>> 20;
      endfunction

      function bit would_reach(req_type p);
         longint unsigned span;
         longint bearing;
         if (reached) return 1'b0;
         steer(p, span, bearing);
         return span <= tolerance;
      endfunction

      function rsp_type predict(req_type p);
         rsp_type r;
         longint unsigned span;
         longint unsigned lin;
         longint bearing;
         longint gain_a;
         longint turn;
         r = '0;
         r.goal_reached = 1'b1;
         if (reached) return r;
         steer(p, span, bearing);
         if (span <= tolerance) begin
            reached = 1'b1;
            return r;
         end
         gain_a = ang_gain;
         lin = (lin_gain * span + 128) >> 8;
         turn = (gain_a * (bearing - longint'($signed(p.heading))) + 128) >>> 8;
         if (lin > LIN_MAX) lin = LIN_MAX;
         if (turn > ANG_MAX) turn = ANG_MAX;
         else if (turn < ANG_MIN) turn = ANG_MIN;
         r.command_valid = 1'b1;
         r.goal_reached = 1'b0;
         r.fwd_speed = lin[LIN_W-1:0];
         r.turn_rate = turn[ANGV_W-1:0];
         return r;
      endfunction

      function void note_pose(req_type p);
         expected_q.push_back(predict(p));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_reply(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected: %p", r);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (r.command_valid !== e.command_valid) begin
            $error("command_valid: expected %0d, got %0d", e.command_valid, r.command_valid);
            errors++;
         end
         if (r.goal_reached !== e.goal_reached) begin
            $error("goal_reached: expected %0d, got %0d", e.goal_reached, r.goal_reached);
            errors++;
         end
         if (r.fwd_speed !== e.fwd_speed) begin
            $error("fwd_speed: expected %0d, got %0d",
                   e.fwd_speed, r.fwd_speed);
            errors++;
         end
         if (r.turn_rate !== e.turn_rate) begin
            $error("turn_rate: expected %0d, got %0d",
                   e.turn_rate, r.turn_rate);
            errors++;
         end
      endfunction
   endclass

   pose_scoreboard sb = new;

   go_to_goal_p_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   always #10 clock = ~clock;

   // response side: check accepted words, random back-pressure and long holds
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_reply(rsp_data);
      if (hold_seen != hold_order) begin
         hold_seen = hold_order;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_type pose_word(int x, int y, int h);
      req_type p;
      p.pose_x = x[POS_W-1:0];
      p.pose_y = y[POS_W-1:0];
      p.heading = h[POS_W-1:0];
      return p;
   endfunction

   function automatic int clip_pos(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // mix of near-goal, on-axis and fully random poses
   function automatic req_type random_pose();
      int gx;
      int gy;
      int h;
      req_type p;
      gx = sb.goal_x;
      gy = sb.goal_y;
      h = ($urandom_range(1) == 0) ? int'($urandom_range(25736)) - 12868
                                   : int'($urandom_range(65535)) - 32768;
      case ($urandom_range(3))
         0: p = pose_word(clip_pos(gx + int'($urandom_range(600)) - 300),
                          clip_pos(gy + int'($urandom_range(600)) - 300), h);
         1: p = ($urandom_range(1) == 0)
                ? pose_word(gx, int'($urandom_range(65535)) - 32768, h)
                : pose_word(int'($urandom_range(65535)) - 32768, gy, h);
         default: p = pose_word(int'($urandom_range(65535)) - 32768,
                                int'($urandom_range(65535)) - 32768, h);
      endcase
      return p;
   endfunction

   // offer one pose word, valid stays high afterwards
   task automatic send_pose(req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_pose(p);
   endtask

   // random poses that keep the goal out of reach
   task automatic send_random(int n);
      req_type p;
      repeat (n) begin
         do p = random_pose(); while (sb.would_reach(p));
         send_pose(p);
      end
   endtask

   // close the batch and wait for every response word
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
   endtask

   // spare indexes first, then every register
   task automatic load_setting(int gx, int gy, int tol, int lg, int ag);
      for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
         write_reg(i[CSR_IDX_W-1:0], POS_W'($urandom));
      write_reg(REG_GOAL_X, gx[POS_W-1:0]);
      write_reg(REG_GOAL_Y, gy[POS_W-1:0]);
      write_reg(REG_REACH_TOLERANCE, tol[POS_W-1:0]);
      write_reg(REG_LINEAR_GAIN, lg[POS_W-1:0]);
      write_reg(REG_ANGULAR_GAIN, ag[POS_W-1:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      req_type p;
      longint unsigned span;
      longint bearing;
      int gx;
      int gy;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed poses with reset values: extremes, quadrants and axes
      send_pose(pose_word(-32768, -32768, -32768));
      send_pose(pose_word(32767, 32767, 32767));
      send_pose(pose_word(32767, -32768, 0));
      send_pose(pose_word(1000, 0, 0));
      send_pose(pose_word(-1000, 0, 12868));
      send_pose(pose_word(0, -1000, -12868));
      send_pose(pose_word(0, 1000, 6434));
      send_pose(pose_word(-32768, 32767, -32768));
      drain();

      // widest vectors, full gains, one-lsb distances
      load_setting(32767, -32768, 0, 65535, 65535);
      send_pose(pose_word(-32768, 32767, -32768));
      send_pose(pose_word(-32768, 32767, 32767));
      send_pose(pose_word(32767, -32767, 0));
      send_pose(pose_word(32766, -32768, 0));
      send_pose(pose_word(-32768, -32768, 0));
      send_pose(pose_word(32767, 32767, -32768));
      drain();

      // zero gains, widest tolerance
      load_setting(-32768, 32767, 65535, 0, 0);
      send_pose(pose_word(32767, -32768, -32768));
      send_pose(pose_word(32767, -100, 32767));
      drain();

      // random batches under several settings and idling patterns
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_setting($urandom, $urandom, $urandom_range(1023), $urandom, $urandom);
            1: load_setting(-32768, -32768, 65535, 65535, 65535);
            2: load_setting(32767, 32767, 0, 0, 0);
            3: load_setting($urandom, $urandom, $urandom_range(1023), $urandom, $urandom);
            4: load_setting($urandom, $urandom, $urandom, $urandom, $urandom);
            default: load_setting($urandom, $urandom, 1, 256, 256);
         endcase
         if (ph < 2) begin
            send_idle_pct = 14;
            recv_idle_pct = 59;
         end else if (ph < 4) begin
            send_idle_pct = 59;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 2) begin
            // long receiver hold while poses keep coming
            send_random(20);
            hold_order++;
            send_random(80);
         end else begin
            send_random(100);
         end
         drain();
      end

      // tolerance boundary: one lsb above, then exactly at the distance
      gx = $signed(16'($urandom_range(60000))) / 2;
      gy = $signed(16'($urandom_range(60000))) / 2;
      p = pose_word(gx + 700, gy - 300, $urandom);
      load_setting(gx, gy, 384, 384, 1536);
      sb.steer(p, span, bearing);
      load_setting(gx, gy, int'(span) - 1, 384, 1536);
      send_pose(p);
      drain();
      load_setting(gx, gy, int'(span), 384, 1536);
      send_pose(p);

      // goal held: pose on the goal and random poses all get no command
      send_pose(pose_word(gx, gy, 0));
      send_idle_pct = 14;
      recv_idle_pct = 59;
      repeat (25) send_pose(random_pose());
      drain();

      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("** go_to_goal_p_controller_core: PASSED **");
      else
         $display("** go_to_goal_p_controller_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("** go_to_goal_p_controller_core: FAILED **");
      $finish;
   end

endmodule
